/* hdl/rilp_pkg.sv */
// Shared types, constants and helper functions of the RIFF INFO list parser.
package rilp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HALTED = 3'd0,
        PH_INFO   = 3'd1,
        PH_HDR    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_PAD    = 3'd4
    } phase_t;

    // Field codes
    localparam logic [2:0] FIELD_INAM = 3'd0;
    localparam logic [2:0] FIELD_IART = 3'd1;
    localparam logic [2:0] FIELD_IPRD = 3'd2;
    localparam logic [2:0] FIELD_IGNR = 3'd3;
    localparam logic [2:0] FIELD_ICRD = 3'd4;
    localparam logic [2:0] FIELD_NONE = 3'd7;

    // Record kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Subchunk ids, first byte in the high bits
    localparam logic [31:0] ID_INFO = 32'h494E_464F;
    localparam logic [31:0] ID_INAM = 32'h494E_414D;
    localparam logic [31:0] ID_IART = 32'h4941_5254;
    localparam logic [31:0] ID_IPRD = 32'h4950_5244;
    localparam logic [31:0] ID_IGNR = 32'h4947_4E52;
    localparam logic [31:0] ID_ICRD = 32'h4943_5244;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Output queue depth and pointer widths
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One result record
    typedef struct packed {
        logic        kind;
        logic [2:0]  code;
        logic [7:0]  value_byte;
        logic [31:0] byte_index;
        logic [31:0] trimmed_length;
        logic [13:0] year_value;
        logic        last;
    } record_t;

    // Records produced by one accepted byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        record_t    rec0;
        record_t    rec1;
    } results_t;

    // Map a subchunk id to its field code
    function automatic logic [2:0] field_of(input logic [31:0] tag);
        logic [2:0] code;
        code = FIELD_NONE;
        if (tag == ID_INAM) code = FIELD_INAM;
        if (tag == ID_IART) code = FIELD_IART;
        if (tag == ID_IPRD) code = FIELD_IPRD;
        if (tag == ID_IGNR) code = FIELD_IGNR;
        if (tag == ID_ICRD) code = FIELD_ICRD;
        return code;
    endfunction

    // Byte of the list type id expected at header position idx
    function automatic logic [7:0] info_byte(input logic [1:0] idx);
        return ID_INFO[{~idx, 3'b000} +: 8];
    endfunction

endpackage

/* hdl/riff_info_list_parser_core.sv */
// RIFF INFO list parser top level: stream ports, parser and output queue.
// Records enter the output queue when their byte is accepted and leave it on the master side.
// Throughput: one byte per cycle while tready is high; a byte that closes a text field
// gives two records, which leave the queue one at a time; a four-entry output queue
// absorbs them and tready drops while fewer than two entries are free.
// Reset (rst_n low, asynchronous): parser halted until a first byte, queue empty.
module riff_info_list_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] in_byte, [39:8] body_length
    input  logic [0:0]  s_axis_tuser,   // [0] first_flag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [7:0] value_byte, [39:8] byte_index,
                                        // [71:40] trimmed_length, [85:72] year_value
    output logic [3:0]  m_axis_tuser,   // [0] record_kind, [3:1] field_code
    output logic        m_axis_tlast    // last_of_run
);

    logic               accept;
    logic               room;
    rilp_pkg::results_t res;
    rilp_pkg::record_t  out_rec;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    rilp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_axis_tdata[7:0]),
        .first_flag  (s_axis_tuser[0]),
        .body_length (s_axis_tdata[39:8]),
        .res         (res)
    );

    rilp_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    // Output packing
    assign m_axis_tdata = {2'b00, out_rec.year_value, out_rec.trimmed_length,
                           out_rec.byte_index, out_rec.value_byte};
    assign m_axis_tuser = {out_rec.code, out_rec.kind};
    assign m_axis_tlast = out_rec.last;

endmodule

/* hdl/rilp_parser.sv */
// Byte-wise RIFF INFO list parser state and record generation.
module rilp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                first_flag,
    input  logic [31:0]         body_length,
    output rilp_pkg::results_t  res
);

    rilp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hc_reg, hc_next;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] nonnull_reg, nonnull_next;
    logic [2:0]  field_reg, field_next;
    logic [13:0] year_reg, year_next;
    logic        year_ok_reg, year_ok_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rilp_pkg::PH_HALTED;
            hc_reg      <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            tag_reg     <= '0;
            size_reg    <= '0;
            count_reg   <= '0;
            nonnull_reg <= '0;
            field_reg   <= '0;
            year_reg    <= '0;
            year_ok_reg <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            hc_reg      <= hc_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            tag_reg     <= tag_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            nonnull_reg <= nonnull_next;
            field_reg   <= field_next;
            year_reg    <= year_next;
            year_ok_reg <= year_ok_next;
        end
    end

    rilp_pkg::phase_t eff_phase;
    logic [2:0]  eff_hc;
    logic [32:0] eff_pos;
    logic [31:0] eff_total;
    logic [32:0] pos_inc;
    logic        bnd_halt;
    logic [31:0] size_hdr;
    logic [33:0] padded_end;
    logic [31:0] cnt_inc;
    logic [31:0] nonnull_new;
    logic [13:0] year_new;
    logic        year_ok_new;
    logic        is_digit;
    logic [3:0]  digit;
    logic        text_end;
    logic        date_end;
    rilp_pkg::record_t byte_rec;
    rilp_pkg::record_t end_rec;

    // Next state and records
    always_comb
    begin
        phase_next   = phase_reg;
        hc_next      = hc_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        tag_next     = tag_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        nonnull_next = nonnull_reg;
        field_next   = field_reg;
        year_next    = year_reg;
        year_ok_next = year_ok_reg;
        res          = '0;

        // A first byte restarts the list
        if (first_flag)
        begin
            eff_phase = (body_length < 32'd4) ? rilp_pkg::PH_HALTED : rilp_pkg::PH_INFO;
            eff_hc    = '0;
            eff_pos   = '0;
            eff_total = body_length;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_hc    = hc_reg;
            eff_pos   = pos_reg;
            eff_total = total_reg;
        end

        pos_inc  = eff_pos + 33'd1;
        // Halt at a subchunk boundary when fewer than 8 bytes remain
        bnd_halt = ({1'b0, pos_inc} + 34'd8) > {2'b00, eff_total};

        // Header size with the current byte placed in its lane
        size_hdr = size_reg;
        size_hdr[{eff_hc[1:0], 3'b000} +: 8] = in_byte;
        padded_end = {1'b0, pos_inc} + {2'b00, size_hdr} + {33'd0, size_hdr[0]};

        // Value byte bookkeeping
        cnt_inc     = count_reg + 32'd1;
        nonnull_new = (in_byte != 8'd0) ? cnt_inc : nonnull_reg;
        is_digit    = (in_byte >= rilp_pkg::CHAR_ZERO) && (in_byte <= rilp_pkg::CHAR_NINE);
        digit       = in_byte[3:0];
        year_new    = year_reg;
        year_ok_new = year_ok_reg;
        if (field_reg == rilp_pkg::FIELD_ICRD && count_reg < 32'd4)
        begin
            if (is_digit)
                year_new = {year_reg[10:0], 3'b000} + {year_reg[12:0], 1'b0}
                           + {10'd0, digit};
            else
                year_ok_new = 1'b0;
        end
        text_end = (field_reg <= rilp_pkg::FIELD_IGNR) && (nonnull_new != 32'd0);
        date_end = (field_reg == rilp_pkg::FIELD_ICRD) && (size_reg >= 32'd4)
                   && year_ok_new && (year_new != 14'd0);

        byte_rec                = '0;
        byte_rec.kind           = rilp_pkg::KIND_BYTE;
        byte_rec.code           = field_reg;
        byte_rec.value_byte     = in_byte;
        byte_rec.byte_index     = count_reg;

        end_rec                 = '0;
        end_rec.kind            = rilp_pkg::KIND_END;
        end_rec.code            = field_reg;
        end_rec.trimmed_length  = nonnull_new;
        end_rec.year_value      = date_end ? year_new : 14'd0;
        end_rec.last            = 1'b1;

        if (accept)
        begin
            if (first_flag)
            begin
                phase_next = eff_phase;
                hc_next    = eff_hc;
                pos_next   = eff_pos;
                total_next = eff_total;
            end
            if (eff_phase != rilp_pkg::PH_HALTED)
            begin
                pos_next = pos_inc;
                unique case (eff_phase)
                    rilp_pkg::PH_HALTED:
                    begin
                        phase_next = rilp_pkg::PH_HALTED;
                    end
                    rilp_pkg::PH_INFO:
                    begin
                        if (in_byte != rilp_pkg::info_byte(eff_hc[1:0]))
                            phase_next = rilp_pkg::PH_HALTED;
                        else if (eff_hc == 3'd3)
                        begin
                            phase_next = bnd_halt ? rilp_pkg::PH_HALTED : rilp_pkg::PH_HDR;
                            hc_next    = '0;
                            tag_next   = '0;
                            size_next  = '0;
                        end
                        else
                            hc_next = eff_hc + 3'd1;
                    end
                    rilp_pkg::PH_HDR:
                    begin
                        hc_next = eff_hc + 3'd1;
                        if (!eff_hc[2])
                            tag_next = {tag_reg[23:0], in_byte};
                        else
                            size_next = size_hdr;
                        if (eff_hc == 3'd7)
                        begin
                            if (padded_end > {2'b00, eff_total})
                                phase_next = rilp_pkg::PH_HALTED;
                            else
                            begin
                                field_next   = rilp_pkg::field_of(tag_reg);
                                count_next   = '0;
                                nonnull_next = '0;
                                year_next    = '0;
                                year_ok_next = 1'b1;
                                if (size_hdr == 32'd0)
                                begin
                                    phase_next = bnd_halt ? rilp_pkg::PH_HALTED
                                                          : rilp_pkg::PH_HDR;
                                    hc_next    = '0;
                                    tag_next   = '0;
                                    size_next  = '0;
                                end
                                else
                                    phase_next = rilp_pkg::PH_VALUE;
                            end
                        end
                    end
                    rilp_pkg::PH_VALUE:
                    begin
                        count_next   = cnt_inc;
                        nonnull_next = nonnull_new;
                        year_next    = year_new;
                        year_ok_next = year_ok_new;
                        if (field_reg <= rilp_pkg::FIELD_IGNR)
                        begin
                            res.count     = 2'd1;
                            res.rec0      = byte_rec;
                            res.rec0.last = 1'b1;
                        end
                        if (cnt_inc == size_reg)
                        begin
                            // End of field record
                            if (text_end)
                            begin
                                res.count     = 2'd2;
                                res.rec0.last = 1'b0;
                                res.rec1      = end_rec;
                            end
                            else if (date_end)
                            begin
                                res.count = 2'd1;
                                res.rec0  = end_rec;
                            end
                            if (size_reg[0])
                                phase_next = rilp_pkg::PH_PAD;
                            else
                            begin
                                phase_next = bnd_halt ? rilp_pkg::PH_HALTED
                                                      : rilp_pkg::PH_HDR;
                                hc_next    = '0;
                                tag_next   = '0;
                                size_next  = '0;
                            end
                        end
                    end
                    rilp_pkg::PH_PAD:
                    begin
                        phase_next = bnd_halt ? rilp_pkg::PH_HALTED : rilp_pkg::PH_HDR;
                        hc_next    = '0;
                        tag_next   = '0;
                        size_next  = '0;
                    end
                    default:
                    begin
                        phase_next = rilp_pkg::PH_HALTED;
                    end
                endcase
            end
        end
    end

endmodule

/* hdl/rilp_out_queue.sv */
// Small output queue that takes up to two records per cycle and delivers one when out_ready is high.
module rilp_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rilp_pkg::results_t res,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output rilp_pkg::record_t  out_rec
);

    rilp_pkg::record_t mem [rilp_pkg::QUEUE_DEPTH];

    logic [rilp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rilp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rilp_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic [rilp_pkg::QPTR_W-1:0] wr_ptr_plus;
    logic [rilp_pkg::QCNT_W-1:0] push_cnt;
    logic                        pop;

    assign wr_ptr_plus = wr_ptr_reg + rilp_pkg::QPTR_W'(1);
    assign push_cnt    = push ? rilp_pkg::QCNT_W'(res.count) : '0;
    assign pop         = out_valid && out_ready;

    // Room for a full pair of records from the next byte
    assign room      = cnt_reg <= rilp_pkg::QCNT_W'(rilp_pkg::QUEUE_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_rec   = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt[rilp_pkg::QPTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + rilp_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + push_cnt - (pop ? rilp_pkg::QCNT_W'(1) : rilp_pkg::QCNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        if (push && res.count != 2'd0)
            mem[wr_ptr_reg] <= res.rec0;
        if (push && res.count == 2'd2)
            mem[wr_ptr_plus] <= res.rec1;
    end

endmodule

/* dv/rilp_tb_pkg.sv */
// Scoreboard package: byte-level predictor and record checker for the INFO list parser.
package rilp_tb_pkg;

    import rilp_pkg::*;

    class info_record_board;
        // Predictor copy of the parser state
        phase_t      phase;
        int unsigned hdr_cnt;
        logic [32:0] pos;
        logic [31:0] total;
        logic [31:0] tag;
        logic [31:0] vsize;
        logic [31:0] vcount;
        logic [31:0] nonnull;
        logic [2:0]  field;
        int unsigned year;
        logic        year_ok;

        // Records still owed by the block, oldest first
        record_t     pending_records[$];
        int unsigned mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase   = PH_HALTED;
            hdr_cnt = 0;
            pos     = '0;
            total   = '0;
            tag     = '0;
            vsize   = '0;
            vcount  = '0;
            nonnull = '0;
            field   = FIELD_INAM;
            year    = 0;
            year_ok = 1'b1;
        endfunction

        // Subchunk boundary: another header needs at least 8 bytes left
        function void next_subchunk();
            if (pos >= {1'b0, total} || {1'b0, total} - pos < 33'd8) begin
                phase = PH_HALTED;
            end
            else begin
                phase   = PH_HDR;
                hdr_cnt = 0;
                tag     = '0;
                vsize   = '0;
            end
        endfunction

        function logic [2:0] code_of_tag(logic [31:0] id);
            case (id)
                ID_INAM: return FIELD_INAM;
                ID_IART: return FIELD_IART;
                ID_IPRD: return FIELD_IPRD;
                ID_IGNR: return FIELD_IGNR;
                ID_ICRD: return FIELD_ICRD;
                default: return FIELD_NONE;
            endcase
        endfunction

        function record_t make_rec(logic kind, logic [2:0] code, logic [7:0] vb,
                                   logic [31:0] idx, logic [31:0] tl, logic [13:0] yr);
            record_t r;
            r.kind           = kind;
            r.code           = code;
            r.value_byte     = vb;
            r.byte_index     = idx;
            r.trimmed_length = tl;
            r.year_value     = yr;
            r.last           = 1'b0;
            return r;
        endfunction

        // Advance the predictor by one accepted byte and queue its records
        function void take_byte(logic [7:0] b, logic first, logic [31:0] len);
            record_t     recs[$];
            logic [63:0] padded;
            if (first) begin
                restart();
                total = len;
                phase = (len < 32'd4) ? PH_HALTED : PH_INFO;
            end
            if (phase == PH_HALTED)
                return;
            pos++;
            case (phase)
                PH_INFO:
                begin
                    if (b != ID_INFO[8 * (3 - hdr_cnt) +: 8]) begin
                        phase = PH_HALTED;
                    end
                    else begin
                        hdr_cnt++;
                        if (hdr_cnt >= 4)
                            next_subchunk();
                    end
                end
                PH_HDR:
                begin
                    if (hdr_cnt < 4)
                        tag = {tag[23:0], b};
                    else
                        vsize = vsize | (32'(b) << (8 * (hdr_cnt - 4)));
                    hdr_cnt++;
                    if (hdr_cnt >= 8) begin
                        padded = 64'(pos) + 64'(vsize) + 64'(vsize[0]);
                        if (padded > 64'(total)) begin
                            // value would run past the list end
                            phase = PH_HALTED;
                        end
                        else begin
                            field   = code_of_tag(tag);
                            vcount  = '0;
                            nonnull = '0;
                            year    = 0;
                            year_ok = 1'b1;
                            if (vsize == 32'd0)
                                next_subchunk();
                            else
                                phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    if (field <= FIELD_IGNR)
                        recs.push_back(make_rec(KIND_BYTE, field, b, vcount, '0, '0));
                    // date field: first four characters form the year
                    if (field == FIELD_ICRD && vcount < 32'd4) begin
                        if (b >= CHAR_ZERO && b <= CHAR_NINE)
                            year = year * 10 + 32'(b - CHAR_ZERO);
                        else
                            year_ok = 1'b0;
                    end
                    if (b != 8'd0)
                        nonnull = vcount + 32'd1;
                    vcount++;
                    if (vcount == vsize) begin
                        if (field <= FIELD_IGNR && nonnull != 32'd0)
                            recs.push_back(make_rec(KIND_END, field, '0, '0, nonnull, '0));
                        if (field == FIELD_ICRD && vsize >= 32'd4 && year_ok && year != 0)
                            recs.push_back(make_rec(KIND_END, FIELD_ICRD, '0, '0, nonnull,
                                                    year[13:0]));
                        if (vsize[0])
                            phase = PH_PAD;
                        else
                            next_subchunk();
                    end
                end
                PH_PAD:
                begin
                    next_subchunk();
                end
                default:
                begin
                    phase = PH_HALTED;
                end
            endcase
            if (recs.size() > 0)
                recs[recs.size() - 1].last = 1'b1;
            foreach (recs[i])
                pending_records.push_back(recs[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted record with the oldest expectation
        function void check_record(record_t got);
            record_t want;
            if (pending_records.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected record, expected none actual kind %0h code %0h byte %0h",
                         $time, got.kind, got.code, got.value_byte);
                return;
            end
            want = pending_records.pop_front();
            compare_field("record_kind", 32'(want.kind), 32'(got.kind));
            compare_field("field_code", 32'(want.code), 32'(got.code));
            compare_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("trimmed_length", want.trimmed_length, got.trimmed_length);
            compare_field("year_value", 32'(want.year_value), 32'(got.year_value));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

endpackage

/* dv/tb.sv */
// Testbench top for the RIFF INFO list parser core.
module tb;

    import rilp_pkg::*;
    import rilp_tb_pkg::*;

    bit          clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [7:0] in_byte, [39:8] body_length
    logic [0:0]  s_axis_tuser;   // [0] first_flag
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // [7:0] value_byte, [39:8] byte_index,
                                 // [71:40] trimmed_length, [85:72] year_value
    logic [3:0]  m_axis_tuser;   // [0] record_kind, [3:1] field_code
    logic        m_axis_tlast;   // last_of_run

    info_record_board board;
    bit               steady;      // no idling on either side while set
    int unsigned      bytes_sent;
    bit [7:0]         body[$];     // list body under construction

    riff_info_list_parser_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("riff_info_list_parser_core test failed");
        $finish;
    end

    // Drive one byte and wait for its transaction
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] len);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, b};
        s_axis_tuser  <= first;
        do @(posedge clk); while (!s_axis_tready);
        board.take_byte(b, first, len);
        bytes_sent++;
    endtask

    // Send the body under construction; body_length only matters on the first byte
    task automatic send_list(input logic [31:0] declared);
        foreach (body[i])
            send_byte(body[i], i == 0, (i == 0) ? declared : 32'($urandom));
    endtask

    // Hold off the sender until every expected record has arrived
    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (board.pending_records.size() != 0 && guard < 20000);
    endtask

    function automatic void put_word_be(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            body.push_back(w[8 * k +: 8]);
    endfunction

    function automatic void put_word_le(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            body.push_back(w[8 * k +: 8]);
    endfunction

    // Append one random subchunk; returns 1 when its size overruns the list
    function automatic bit add_subchunk();
        logic [31:0] id;
        logic [31:0] size;
        int unsigned style;
        int unsigned trail;
        int unsigned count;
        logic [7:0]  v;
        bit          overrun;
        case ($urandom_range(0, 9))
            0, 1:    id = ID_INAM;
            2:       id = ID_IART;
            3:       id = ID_IPRD;
            4:       id = ID_IGNR;
            5, 6:    id = ID_ICRD;
            7:       id = {ID_IART[31:8], 8'($urandom)};
            default: id = $urandom;
        endcase
        overrun = ($urandom_range(0, 29) == 0);
        if (overrun)
            size = $urandom | 32'h0000_0100;
        else if ($urandom_range(0, 39) == 0)
            size = $urandom_range(10, 40);
        else if ($urandom_range(0, 9) == 0)
            size = 0;
        else
            size = $urandom_range(1, 9);
        put_word_be(id);
        put_word_le(size);
        style = $urandom_range(0, 3);
        trail = $urandom_range(0, 3);
        count = overrun ? 6 : size;
        for (int unsigned k = 0; k < count; k++) begin
            case (style)
                0:       v = $urandom_range(0, 255);
                1:       v = (k + trail >= size) ? 8'd0 : 8'($urandom_range(32, 126));
                2:       v = 8'd0;
                default: v = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            endcase
            // date digits: random year, or an all-zero year for the null style
            if (id == ID_ICRD && k < 4 && style != 0)
                v = (style == 2) ? CHAR_ZERO : CHAR_ZERO + 8'($urandom_range(0, 9));
            body.push_back(v);
        end
        if (!overrun && size[0])
            body.push_back(8'($urandom));
        return overrun;
    endfunction

    // Stimulus
    initial
    begin
        int unsigned lists;
        int unsigned form;
        logic [31:0] declared;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        bytes_sent    = 0;
        board         = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any list start are ignored
        send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0, 32'h0000_0000);
        // body shorter than the list type id
        body.delete();
        put_word_be(ID_INFO);
        send_list(32'd3);
        // wrong list type
        body.delete();
        put_word_be(ID_INFO);
        body[3] = 8'h58;
        send_list(32'd8);
        // date field with the largest year, list ends exactly after it
        body.delete();
        put_word_be(ID_INFO);
        put_word_be(ID_ICRD);
        put_word_le(32'd4);
        repeat (4) body.push_back(CHAR_NINE);
        send_list(32'd16);
        drain();

        // Random lists
        lists = 0;
        while (bytes_sent < 840) begin
            steady = ($urandom_range(0, 5) == 0);
            body.delete();
            form = $urandom_range(0, 9);
            if (form == 0) begin
                // noise body
                repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
            end
            else begin
                put_word_be(ID_INFO);
                repeat ($urandom_range(1, 3))
                    if (add_subchunk())
                        break;
                if (form == 1)
                    body[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            end
            case ($urandom_range(0, 19))
                14, 15:  declared = body.size() + $urandom_range(1, 7);
                16, 17:  declared = $urandom_range(0, body.size());
                18:      declared = 32'hFFFF_FFFF;
                19:      declared = $urandom;
                default: declared = body.size();
            endcase
            send_list(declared);
            // stray bytes between lists
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0, 32'($urandom));
            lists++;
            if (lists % 6 == 0)
                drain();
        end

        steady = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending_records.size() == 0)
            $display("riff_info_list_parser_core test passed");
        else
            $display("riff_info_list_parser_core test failed");
        $finish;
    end

    // Record receiver with random stalls
    initial
    begin
        int unsigned stall;
        record_t     got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got.kind           = m_axis_tuser[0];
            got.code           = m_axis_tuser[3:1];
            got.value_byte     = m_axis_tdata[7:0];
            got.byte_index     = m_axis_tdata[39:8];
            got.trimmed_length = m_axis_tdata[71:40];
            got.year_value     = m_axis_tdata[85:72];
            got.last           = m_axis_tlast;
            board.check_record(got);
        end
    end

endmodule
